// File: rtl/steering_force_unit_top_assert.svh
//------------------------------------------------------------------------------
// steering force unit assertion macros
// same-cycle and next-cycle implication checks, empty when synthesizing
//------------------------------------------------------------------------------
`ifndef STEERING_FORCE_UNIT_TOP_ASSERT_SVH
`define STEERING_FORCE_UNIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// pre holds, post must hold in the same cycle
`define SFU_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("steering force unit check failed");
// pre holds, post must hold in the next cycle
`define SFU_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("steering force unit check failed");
`else
`define SFU_ASSERT_SAME(lbl, clk, rst_n, pre, post)
`define SFU_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/stfu_pkg.sv
//------------------------------------------------------------------------------
// stfu_pkg
// shared types, constants and helpers of the steering force unit
//------------------------------------------------------------------------------
package stfu_pkg;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // pipelined arithmetic units
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;

    // squared distance for a distance below 0.001
    localparam logic [63:0] ARRIVE_MIN_SQ = 64'd4295;
    // look-ahead limit after reset, 2.0
    localparam logic [30:0] MPT_RESET = 31'd131072;

    typedef enum logic [2:0] {
        MODE_SEEK   = 3'd0,
        MODE_FLEE   = 3'd1,
        MODE_ARRIVE = 3'd2,
        MODE_PURSUE = 3'd3,
        MODE_EVADE  = 3'd4
    } mode_t;

    // decoded request
    typedef struct packed {
        logic             flip;
        logic             predict;
        logic             arrive;
        logic             null_mode;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] tgt;
        logic [2:0][31:0] vel;
        logic [30:0]      limit;
        logic [30:0]      radius;
    } ctx_t;

    // queue entry: request plus magnitudes of target minus own
    typedef struct packed {
        ctx_t             ctx;
        logic [2:0][31:0] dmag;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // saturate a wide signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        if ((&v[48:31]) || !(|v[48:31])) begin
            return v[31:0];
        end else if (v[48]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7fff_ffff;
        end
    endfunction

    // magnitude of a signed 32 bit value, 2^31 fits
    function automatic logic [31:0] abs32(input logic [31:0] v);
        if (v[31]) begin
            return 32'(-v);
        end else begin
            return v;
        end
    endfunction

endpackage

// File: rtl/stfu_front.sv
//------------------------------------------------------------------------------
// stfu_front
// accepts items, decodes the mode and forms the first difference vector
//------------------------------------------------------------------------------
module stfu_front
    import stfu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] tgt_x,
    input  logic signed [31:0] tgt_y,
    input  logic signed [31:0] tgt_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [30:0]        force_limit,
    input  logic [30:0]        slow_radius,
    input  q_stat_t            q_stat,
    output item_t              item,
    output logic               item_valid
);

    logic  front_valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  take;

    // hold while the queue cannot take the pending item
    assign in_stall   = front_valid_reg && q_stat.full;
    assign take       = in_valid && !in_stall;
    assign item       = item_reg;
    assign item_valid = front_valid_reg;

    // mode decode and saturated target minus own
    always_comb
    begin
        logic signed [32:0] dd;
        item_next.ctx.flip      = req_type inside {MODE_FLEE, MODE_EVADE};
        item_next.ctx.predict   = req_type inside {MODE_PURSUE, MODE_EVADE};
        item_next.ctx.arrive    = (req_type == MODE_ARRIVE);
        item_next.ctx.null_mode = !(req_type inside {MODE_SEEK, MODE_FLEE, MODE_ARRIVE,
                                                     MODE_PURSUE, MODE_EVADE});
        item_next.ctx.pos    = {pos_z, pos_y, pos_x};
        item_next.ctx.tgt    = {tgt_z, tgt_y, tgt_x};
        item_next.ctx.vel    = {vel_z, vel_y, vel_x};
        item_next.ctx.limit  = force_limit;
        item_next.ctx.radius = slow_radius;
        for (int i = 0; i < 3; i++)
        begin
            dd = 33'($signed(item_next.ctx.tgt[i])) - 33'($signed(item_next.ctx.pos[i]));
            item_next.dmag[i] = abs32(sat32(49'(dd)));
        end
    end

    // front valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            front_valid_reg <= in_valid;
        end
    end

    // front payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/stfu_queue.sv
//------------------------------------------------------------------------------
// stfu_queue
// short item queue between front and back
//------------------------------------------------------------------------------
module stfu_queue
    import stfu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   push_item,
    input  logic    push_valid,
    input  logic    pop,
    output item_t   head,
    output q_stat_t stat
);

    item_t            mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             push;

    assign stat.full  = (count_reg == QCW'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign push       = push_valid && !stat.full;
    assign head       = mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/stfu_sqrt.sv
//------------------------------------------------------------------------------
// stfu_sqrt
// pipelined integer square root of a 64 bit value, one result bit per stage
//------------------------------------------------------------------------------
module stfu_sqrt
    import stfu_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [32:0] root
);

    logic [63:0] v_reg  [SQRT_STAGES];
    logic [63:0] r_reg  [SQRT_STAGES];
    logic [63:0] v_in   [SQRT_STAGES];
    logic [63:0] r_in   [SQRT_STAGES];
    logic [63:0] v_nx   [SQRT_STAGES];
    logic [63:0] r_nx   [SQRT_STAGES];

    assign root = r_reg[SQRT_STAGES-1][32:0];

    // one digit step per stage
    always_comb
    begin
        logic [63:0] b;
        logic [63:0] sum;
        v_in[0] = radicand;
        r_in[0] = '0;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            v_in[k] = v_reg[k-1];
            r_in[k] = r_reg[k-1];
        end
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            b   = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
            sum = r_in[k] + b;
            if (v_in[k] >= sum)
            begin
                v_nx[k] = v_in[k] - sum;
                r_nx[k] = (r_in[k] >> 1) + b;
            end
            else
            begin
                v_nx[k] = v_in[k];
                r_nx[k] = r_in[k] >> 1;
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                v_reg[k] <= v_nx[k];
                r_reg[k] <= r_nx[k];
            end
        end
    end

endmodule

// File: rtl/stfu_div.sv
//------------------------------------------------------------------------------
// stfu_div
// pipelined restoring divider, 63 bit dividend by 33 bit divisor, 31 bit quotient
//------------------------------------------------------------------------------
module stfu_div
    import stfu_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] dividend,
    input  logic [32:0] divisor,
    output logic [30:0] quotient
);

    logic [62:0] rem_reg [DIV_STAGES];
    logic [32:0] den_reg [DIV_STAGES];
    logic [30:0] q_reg   [DIV_STAGES];
    logic [62:0] rem_in  [DIV_STAGES];
    logic [32:0] den_in  [DIV_STAGES];
    logic [30:0] q_in    [DIV_STAGES];
    logic [62:0] rem_nx  [DIV_STAGES];
    logic [30:0] q_nx    [DIV_STAGES];

    assign quotient = q_reg[DIV_STAGES-1];

    // one quotient bit per stage, most significant first
    always_comb
    begin
        logic [62:0] trial;
        rem_in[0] = dividend;
        den_in[0] = divisor;
        q_in[0]   = '0;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            den_in[k] = den_reg[k-1];
            q_in[k]   = q_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            trial = {30'd0, den_in[k]} << (DIV_STAGES - 1 - k);
            if (rem_in[k] >= trial)
            begin
                rem_nx[k] = rem_in[k] - trial;
                q_nx[k]   = q_in[k] | (31'd1 << (DIV_STAGES - 1 - k));
            end
            else
            begin
                rem_nx[k] = rem_in[k];
                q_nx[k]   = q_in[k];
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_nx[k];
                den_reg[k] <= den_in[k];
                q_reg[k]   <= q_nx[k];
            end
        end
    end

endmodule

// File: rtl/stfu_back.sv
//------------------------------------------------------------------------------
// stfu_back
// force pipeline: prediction, second difference, normalize and scale
//------------------------------------------------------------------------------
module stfu_back
    import stfu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [30:0]        mpt,
    input  item_t              head,
    input  logic               head_valid,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z
);

    // what the steer half still needs
    typedef struct packed {
        logic             null_mode;
        logic             arrive;
        logic [30:0]      limit;
        logic [30:0]      radius;
        logic [2:0][31:0] d2;
    } bctx_t;

    logic en;

    // first squares and sum
    logic             v_p1_reg;
    ctx_t             ctx_p1_reg;
    logic [2:0][63:0] sq1_p1_reg;
    logic             v_p2_reg;
    ctx_t             ctx_p2_reg;
    logic [63:0]      s1_p2_reg;

    // alongside first square root
    logic             v_sa_reg   [SQRT_STAGES];
    ctx_t             ctx_sa_reg [SQRT_STAGES];
    logic [32:0]      pred_len;

    // alongside prediction divide
    logic             v_da_reg   [DIV_STAGES];
    ctx_t             ctx_da_reg [DIV_STAGES];
    logic             ovf_da_reg [DIV_STAGES];
    logic             dz_da_reg  [DIV_STAGES];
    logic             ovf_c;
    logic             dz_c;
    logic [30:0]      pq;
    ctx_t             cdl;
    logic [30:0]      t;

    // prediction, future position, second difference
    logic             v_p4_reg;
    ctx_t             ctx_p4_reg;
    logic [2:0][62:0] prod_p4_reg;
    logic [2:0][62:0] prod_next;
    logic             v_p5_reg;
    ctx_t             ctx_p5_reg;
    logic [2:0][47:0] fut_p5_reg;
    logic [2:0][47:0] fut_next;
    logic             v_p6_reg;
    bctx_t            b_p6_reg;
    bctx_t            b_next;

    // second squares and sum
    logic             v_p7_reg;
    bctx_t            b_p7_reg;
    logic [2:0][63:0] sq2_p7_reg;
    logic [61:0]      rad2_p7_reg;
    logic             v_p8_reg;
    bctx_t            b_p8_reg;
    logic [63:0]      s2_p8_reg;
    logic [61:0]      rad2_p8_reg;
    logic             szero_c;
    logic             small_c;
    logic             userad_c;

    // alongside second square root
    logic             v_sb_reg      [SQRT_STAGES];
    bctx_t            b_sb_reg      [SQRT_STAGES];
    logic             szero_sb_reg  [SQRT_STAGES];
    logic             small_sb_reg  [SQRT_STAGES];
    logic             userad_sb_reg [SQRT_STAGES];
    logic [32:0]      root2;
    bctx_t            bl;

    // numerators and divisor
    logic             v_p10_reg;
    logic [2:0][62:0] num_p10_reg;
    logic [32:0]      den_p10_reg;
    logic [2:0]       sgn_p10_reg;
    logic             kill_p10_reg;

    // alongside final divides
    logic             v_dc_reg    [DIV_STAGES];
    logic [2:0]       sgn_dc_reg  [DIV_STAGES];
    logic             kill_dc_reg [DIV_STAGES];
    logic [2:0][30:0] fq;

    // output register
    logic             out_valid_reg;
    logic [2:0][31:0] force_reg;
    logic [2:0][31:0] force_next;

    // the whole pipe moves unless a finished item is held
    assign en        = !out_valid_reg || !out_stall;
    assign pop       = en && head_valid;
    assign out_valid = out_valid_reg;
    assign force_x   = $signed(force_reg[0]);
    assign force_y   = $signed(force_reg[1]);
    assign force_z   = $signed(force_reg[2]);

    // distance for the look-ahead
    stfu_sqrt u_sqrt_pred (
        .clk      (clk),
        .en       (en),
        .radicand (s1_p2_reg),
        .root     (pred_len)
    );

    assign dz_c  = (pred_len == 33'd0);
    assign ovf_c = {13'd0, pred_len} >= {ctx_sa_reg[SQRT_STAGES-1].limit, 15'd0};

    // look-ahead time, distance over force
    stfu_div u_div_pred (
        .clk      (clk),
        .en       (en),
        .dividend ({14'd0, pred_len, 16'd0}),
        .divisor  ({2'd0, ctx_sa_reg[SQRT_STAGES-1].limit}),
        .quotient (pq)
    );

    assign cdl = ctx_da_reg[DIV_STAGES-1];

    // clamp look-ahead time
    always_comb
    begin
        if (!cdl.predict || dz_da_reg[DIV_STAGES-1])
        begin
            t = '0;
        end
        else if ((cdl.limit == '0) || ovf_da_reg[DIV_STAGES-1] || (pq > mpt))
        begin
            t = mpt;
        end
        else
        begin
            t = pq;
        end
    end

    // velocity times time
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = abs32(cdl.vel[i]) * t;
        end
    end

    // predicted position
    always_comb
    begin
        logic signed [47:0] off;
        for (int i = 0; i < 3; i++)
        begin
            off = $signed({1'b0, prod_p4_reg[i][62:16]});
            if (ctx_p4_reg.vel[i][31])
            begin
                off = -off;
            end
            fut_next[i] = 48'($signed(ctx_p4_reg.tgt[i])) + off;
        end
    end

    // second difference vector
    always_comb
    begin
        logic signed [48:0] pe;
        logic signed [48:0] fe;
        b_next.null_mode = ctx_p5_reg.null_mode;
        b_next.arrive    = ctx_p5_reg.arrive;
        b_next.limit     = ctx_p5_reg.limit;
        b_next.radius    = ctx_p5_reg.radius;
        for (int i = 0; i < 3; i++)
        begin
            pe = 49'($signed(ctx_p5_reg.pos[i]));
            fe = 49'($signed(fut_p5_reg[i]));
            b_next.d2[i] = ctx_p5_reg.flip ? sat32(pe - fe) : sat32(fe - pe);
        end
    end

    // distance tests for the steer half
    assign szero_c  = (s2_p8_reg == '0);
    assign small_c  = (s2_p8_reg < ARRIVE_MIN_SQ);
    assign userad_c = b_p8_reg.arrive && (b_p8_reg.radius != '0)
                      && (s2_p8_reg < {2'd0, rad2_p8_reg});

    // distance for normalizing
    stfu_sqrt u_sqrt_steer (
        .clk      (clk),
        .en       (en),
        .radicand (s2_p8_reg),
        .root     (root2)
    );

    assign bl = b_sb_reg[SQRT_STAGES-1];

    // per-component force magnitude
    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_div
            stfu_div u_div_force (
                .clk      (clk),
                .en       (en),
                .dividend (num_p10_reg[gi]),
                .divisor  (den_p10_reg),
                .quotient (fq[gi])
            );
        end
    endgenerate

    // apply sign or zero the force
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (kill_dc_reg[DIV_STAGES-1])
            begin
                force_next[i] = '0;
            end
            else if (sgn_dc_reg[DIV_STAGES-1][i])
            begin
                force_next[i] = -{1'b0, fq[i]};
            end
            else
            begin
                force_next[i] = {1'b0, fq[i]};
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_p1_reg      <= 1'b0;
            v_p2_reg      <= 1'b0;
            v_p4_reg      <= 1'b0;
            v_p5_reg      <= 1'b0;
            v_p6_reg      <= 1'b0;
            v_p7_reg      <= 1'b0;
            v_p8_reg      <= 1'b0;
            v_p10_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                v_sa_reg[k] <= 1'b0;
                v_sb_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                v_da_reg[k] <= 1'b0;
                v_dc_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_p1_reg    <= head_valid;
            v_p2_reg    <= v_p1_reg;
            v_sa_reg[0] <= v_p2_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                v_sa_reg[k] <= v_sa_reg[k-1];
                v_sb_reg[k] <= v_sb_reg[k-1];
            end
            v_da_reg[0] <= v_sa_reg[SQRT_STAGES-1];
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                v_da_reg[k] <= v_da_reg[k-1];
                v_dc_reg[k] <= v_dc_reg[k-1];
            end
            v_p4_reg      <= v_da_reg[DIV_STAGES-1];
            v_p5_reg      <= v_p4_reg;
            v_p6_reg      <= v_p5_reg;
            v_p7_reg      <= v_p6_reg;
            v_p8_reg      <= v_p7_reg;
            v_sb_reg[0]   <= v_p8_reg;
            v_p10_reg     <= v_sb_reg[SQRT_STAGES-1];
            v_dc_reg[0]   <= v_p10_reg;
            out_valid_reg <= v_dc_reg[DIV_STAGES-1];
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // first squares and sum
            ctx_p1_reg <= head.ctx;
            for (int i = 0; i < 3; i++)
            begin
                sq1_p1_reg[i] <= head.dmag[i] * head.dmag[i];
            end
            ctx_p2_reg <= ctx_p1_reg;
            s1_p2_reg  <= sq1_p1_reg[0] + sq1_p1_reg[1] + sq1_p1_reg[2];

            // context beside the first root and the prediction divide
            ctx_sa_reg[0] <= ctx_p2_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                ctx_sa_reg[k] <= ctx_sa_reg[k-1];
            end
            ctx_da_reg[0] <= ctx_sa_reg[SQRT_STAGES-1];
            ovf_da_reg[0] <= ovf_c;
            dz_da_reg[0]  <= dz_c;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                ctx_da_reg[k] <= ctx_da_reg[k-1];
                ovf_da_reg[k] <= ovf_da_reg[k-1];
                dz_da_reg[k]  <= dz_da_reg[k-1];
            end

            // prediction and second difference
            ctx_p4_reg  <= cdl;
            prod_p4_reg <= prod_next;
            ctx_p5_reg  <= ctx_p4_reg;
            fut_p5_reg  <= fut_next;
            b_p6_reg    <= b_next;

            // second squares and sum
            b_p7_reg <= b_p6_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq2_p7_reg[i] <= abs32(b_p6_reg.d2[i]) * abs32(b_p6_reg.d2[i]);
            end
            rad2_p7_reg <= b_p6_reg.radius * b_p6_reg.radius;
            b_p8_reg    <= b_p7_reg;
            s2_p8_reg   <= sq2_p7_reg[0] + sq2_p7_reg[1] + sq2_p7_reg[2];
            rad2_p8_reg <= rad2_p7_reg;

            // context beside the second root
            b_sb_reg[0]      <= b_p8_reg;
            szero_sb_reg[0]  <= szero_c;
            small_sb_reg[0]  <= small_c;
            userad_sb_reg[0] <= userad_c;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                b_sb_reg[k]      <= b_sb_reg[k-1];
                szero_sb_reg[k]  <= szero_sb_reg[k-1];
                small_sb_reg[k]  <= small_sb_reg[k-1];
                userad_sb_reg[k] <= userad_sb_reg[k-1];
            end

            // numerators, divisor, signs, zero flag
            for (int i = 0; i < 3; i++)
            begin
                num_p10_reg[i] <= abs32(bl.d2[i]) * bl.limit;
                sgn_p10_reg[i] <= bl.d2[i][31];
            end
            den_p10_reg  <= userad_sb_reg[SQRT_STAGES-1] ? {2'd0, bl.radius} : root2;
            kill_p10_reg <= bl.null_mode || szero_sb_reg[SQRT_STAGES-1]
                            || (bl.arrive && small_sb_reg[SQRT_STAGES-1]);

            // signs and zero flags beside the final divides
            sgn_dc_reg[0]  <= sgn_p10_reg;
            kill_dc_reg[0] <= kill_p10_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                sgn_dc_reg[k]  <= sgn_dc_reg[k-1];
                kill_dc_reg[k] <= kill_dc_reg[k-1];
            end

            force_reg <= force_next;
        end
    end

endmodule

// File: rtl/steering_force_unit_top.sv
//------------------------------------------------------------------------------
// steering_force_unit_top
// seek, flee, arrive, pursue and evade forces in signed q16.16
//------------------------------------------------------------------------------
// channel   handshake          payload
// cfg       cfg_valid/ready    cfg_data: max prediction time
// in        in_valid/in_stall  req_type, pos, tgt, vel, force_limit, slow_radius
// out       out_valid/stall    force_x, force_y, force_z
//
// one item per cycle sustained while the output is not stalled; the back
// pipeline holds two 32-stage square roots and two 31-stage divider steps
// reset clears valids and loads max prediction time with 2.0
// an output stall on a valid result freezes the back pipeline; the queue and front keep
// taking items until the queue fills
//------------------------------------------------------------------------------
`include "steering_force_unit_top_assert.svh"

module steering_force_unit_top
    import stfu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] tgt_x,
    input  logic signed [31:0] tgt_y,
    input  logic signed [31:0] tgt_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [30:0]        force_limit,
    input  logic [30:0]        slow_radius,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z
);

    logic [30:0] mpt_reg;
    item_t       f_item;
    logic        f_valid;
    item_t       q_head;
    q_stat_t     q_stat;
    logic        pop;

    assign cfg_ready = 1'b1;

    // prediction limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpt_reg <= MPT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mpt_reg <= cfg_data;
        end
    end

    // accept and decode
    stfu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .tgt_x       (tgt_x),
        .tgt_y       (tgt_y),
        .tgt_z       (tgt_z),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .vel_z       (vel_z),
        .force_limit (force_limit),
        .slow_radius (slow_radius),
        .q_stat      (q_stat),
        .item        (f_item),
        .item_valid  (f_valid)
    );

    // decoupling queue
    stfu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (f_item),
        .push_valid (f_valid),
        .pop        (pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    // force pipeline
    stfu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mpt        (mpt_reg),
        .head       (q_head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .force_x    (force_x),
        .force_y    (force_y),
        .force_z    (force_z)
    );

    // checks
    `SFU_ASSERT_SAME(a_no_pop_when_held, clk, rst_n, out_valid && out_stall, !pop)
    `SFU_ASSERT_SAME(a_pop_needs_item, clk, rst_n, pop, !q_stat.empty)
    `SFU_ASSERT_NEXT(a_accept_fills_front, clk, rst_n, in_valid && !in_stall, f_valid)

endmodule

// File: tb/tb_steering_force_unit_top.sv
//------------------------------------------------------------------------------
// tb_steering_force_unit_top
// self-checking bench for the steering force unit: a directed table of
// corner items, then random items under several idle and stall mixes and
// look-ahead limits, each result compared with a table value or a bit-true force predictor
//------------------------------------------------------------------------------
module tb_steering_force_unit_top;
    import stfu_pkg::*;

    typedef struct packed {
        logic [2:0]       mode;
        logic [2:0][31:0] p;
        logic [2:0][31:0] t;
        logic [2:0][31:0] v;
        logic [30:0]      lim;
        logic [30:0]      rad;
    } req_t;

    typedef logic [2:0][31:0] force_t;
    typedef longint vec3_t [3];

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [30:0] LIM_MAX = 31'h7fff_ffff;
    localparam int DRAIN_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    req_t        drv = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [31:0] force_x, force_y, force_z;

    // expectation riding along with the driven item
    logic        drv_has_exp = 1'b0;
    force_t      drv_exp = '0;

    force_t      pending_forces[$];
    logic [30:0] look_ahead_max = MPT_RESET;
    int          errors = 0;
    int          items_sent = 0;
    int          forces_seen = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          mode_count[8];

    always #5 clk = ~clk;

    steering_force_unit_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (drv.mode),
        .pos_x       (drv.p[0]),
        .pos_y       (drv.p[1]),
        .pos_z       (drv.p[2]),
        .tgt_x       (drv.t[0]),
        .tgt_y       (drv.t[1]),
        .tgt_z       (drv.t[2]),
        .vel_x       (drv.v[0]),
        .vel_y       (drv.v[1]),
        .vel_z       (drv.v[2]),
        .force_limit (drv.lim),
        .slow_radius (drv.rad),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .force_x     (force_x),
        .force_y     (force_y),
        .force_z     (force_z)
    );

    //--------------------------------------------------------------------------
    // force predictor
    //--------------------------------------------------------------------------
    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // d * num / den, truncated toward zero
    function automatic longint ratio_scale(input longint d, input longint unsigned num,
                                           input longint unsigned den);
        longint unsigned q;
        q = (abs64(d) * num) / den;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic force_t steer_force(input vec3_t fr, input vec3_t to,
                                           input longint unsigned lim,
                                           input longint unsigned rad, input bit arrive);
        longint d[3];
        longint unsigned sq, den;
        force_t f;
        sq = 0;
        f = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = clip32(to[i] - fr[i]);
            sq += abs64(d[i]) * abs64(d[i]);
        end
        if (sq == 0) return f;
        // arrive: dead zone, then linear slowdown inside the radius
        if (arrive) begin
            if (sq < ARRIVE_MIN_SQ) return f;
            if (rad > 0 && sq < rad * rad) begin
                for (int i = 0; i < 3; i++) f[i] = 32'(ratio_scale(d[i], lim, rad));
                return f;
            end
        end
        den = int_sqrt(sq);
        for (int i = 0; i < 3; i++) f[i] = 32'(ratio_scale(d[i], lim, den));
        return f;
    endfunction

    function automatic force_t predict_force(input req_t r);
        vec3_t pos, tgt, fut;
        longint unsigned sq, span, tla;
        longint d;
        force_t f;
        f = '0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(r.p[i]));
            tgt[i] = longint'($signed(r.t[i]));
        end
        case (r.mode)
            MODE_SEEK:   f = steer_force(pos, tgt, r.lim, 0, 1'b0);
            MODE_FLEE:   f = steer_force(tgt, pos, r.lim, 0, 1'b0);
            MODE_ARRIVE: f = steer_force(pos, tgt, r.lim, r.rad, 1'b1);
            MODE_PURSUE, MODE_EVADE:
            begin
                // look-ahead time from distance over force, capped
                for (int i = 0; i < 3; i++) begin
                    d = clip32(tgt[i] - pos[i]);
                    sq += abs64(d) * abs64(d);
                end
                span = int_sqrt(sq);
                if (span == 0) tla = 0;
                else if (r.lim == 0) tla = look_ahead_max;
                else begin
                    tla = (span << 16) / r.lim;
                    if (tla > look_ahead_max) tla = look_ahead_max;
                end
                for (int i = 0; i < 3; i++)
                    fut[i] = tgt[i] + ratio_scale(longint'($signed(r.v[i])), tla, 65536);
                if (r.mode == MODE_PURSUE) f = steer_force(pos, fut, r.lim, 0, 1'b0);
                else f = steer_force(fut, pos, r.lim, 0, 1'b0);
            end
            default: f = '0;
        endcase
        return f;
    endfunction

    //--------------------------------------------------------------------------
    // input monitor: queue a table value or a prediction for every accepted item
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall) begin
            pending_forces.push_back(drv_has_exp ? drv_exp : predict_force(drv));
            mode_count[drv.mode]++;
        end
    end

    //--------------------------------------------------------------------------
    // output monitor: compare with the oldest expected force
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin
        force_t want;
        if (rst_n && out_valid && !out_stall) begin
            forces_seen++;
            if (pending_forces.size() == 0) begin
                $display("%0t: unexpected item x=%h y=%h z=%h", $time,
                         force_x, force_y, force_z);
                errors++;
            end else begin
                want = pending_forces.pop_front();
                if (force_x !== want[0]) begin
                    $display("%0t: force_x expected %h actual %h", $time, want[0], force_x);
                    errors++;
                end
                if (force_y !== want[1]) begin
                    $display("%0t: force_y expected %h actual %h", $time, want[1], force_y);
                    errors++;
                end
                if (force_z !== want[2]) begin
                    $display("%0t: force_z expected %h actual %h", $time, want[2], force_z);
                    errors++;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // receiver stall, with a long hold when requested
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0) begin
            hold_left <= 400;
            hold_req <= 1'b0;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    //--------------------------------------------------------------------------
    // driver tasks
    //--------------------------------------------------------------------------
    task automatic send_item(input req_t r, input bit has_exp, input force_t exp_f);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        drv <= r;
        drv_has_exp <= has_exp;
        drv_exp <= exp_f;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic write_look_ahead(input logic [30:0] v);
        in_valid <= 1'b0;
        wait (pending_forces.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        look_ahead_max = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
            2: return $urandom_range(1) ? NEG_MAX : POS_MAX;
            default: return 32'($signed($urandom_range(65536)) - 32768);
        endcase
    endfunction

    function automatic req_t rand_req();
        req_t r;
        r.mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        for (int i = 0; i < 3; i++) begin
            r.p[i] = rand_coord();
            // nearby target most of the time so arrive and small distances occur
            r.t[i] = ($urandom_range(2) == 0) ? rand_coord()
                                              : r.p[i] + 32'($signed($urandom_range(8)) - 4);
            r.v[i] = ($urandom_range(1)) ? $urandom() : rand_coord();
        end
        case ($urandom_range(4))
            0: r.lim = '0;
            1: r.lim = LIM_MAX;
            default: r.lim = 31'($urandom());
        endcase
        case ($urandom_range(3))
            0: r.rad = '0;
            1: r.rad = 31'($urandom_range(16));
            default: r.rad = 31'($urandom());
        endcase
        return r;
    endfunction

    //--------------------------------------------------------------------------
    // directed table and random phases
    //--------------------------------------------------------------------------
    req_t   dir_req[$];
    bit     dir_has[$];
    force_t dir_exp[$];

    task automatic add_row(input req_t r, input bit has_exp, input force_t e);
        dir_req.push_back(r);
        dir_has.push_back(has_exp);
        dir_exp.push_back(e);
    endtask

    initial
    begin
        req_t r;
        force_t z;
        int idle_mix[4];
        int stall_mix[4];
        logic [30:0] limits[4];
        z = '0;
        idle_mix  = '{0, 71, 0, 29};
        stall_mix = '{0, 0, 71, 29};
        limits    = '{31'd0, LIM_MAX, 31'h0000_8000, 31'h0003_0000};

        // unit step along x: seek gives the full limit, flee its negative
        r = '0; r.mode = MODE_SEEK; r.t[0] = ONE; r.lim = 31'h2_0000;
        add_row(r, 1, '{32'd0, 32'd0, 32'h0002_0000});
        r.mode = MODE_FLEE;
        add_row(r, 1, '{32'd0, 32'd0, 32'hfffe_0000});
        // zero distance for seek, flee, pursue, evade
        r = '0; r.lim = LIM_MAX; r.p = '{32'h1234, 32'h5678, 32'h9abc}; r.t = r.p;
        r.v = '{POS_MAX, NEG_MAX, ONE};
        for (int m = MODE_SEEK; m <= MODE_EVADE; m++)
            if (m != MODE_ARRIVE) begin r.mode = 3'(m); add_row(r, 1, z); end
        // arrive inside the dead zone
        r.mode = MODE_ARRIVE; r.t[0] = r.p[0] + 32'd1;
        add_row(r, 1, z);
        // unknown modes
        r = '0; r.t[1] = ONE; r.lim = LIM_MAX;
        for (int m = 5; m < 8; m++) begin r.mode = 3'(m); add_row(r, 1, z); end
        // zero force limit in every mode
        r = '0; r.t = '{POS_MAX, NEG_MAX, ONE}; r.v = '{ONE, ONE, NEG_MAX}; r.rad = LIM_MAX;
        for (int m = MODE_SEEK; m <= MODE_EVADE; m++) begin r.mode = 3'(m); add_row(r, 1, z); end
        // saturating differences at the range extremes
        r = '0; r.p = '{NEG_MAX, POS_MAX, NEG_MAX}; r.t = '{POS_MAX, NEG_MAX, 32'd0};
        r.v = '{POS_MAX, NEG_MAX, POS_MAX}; r.lim = LIM_MAX; r.rad = LIM_MAX;
        for (int m = MODE_SEEK; m <= MODE_EVADE; m++) begin r.mode = 3'(m); add_row(r, 0, z); end
        // arrive inside and outside a slow radius
        r = '0; r.mode = MODE_ARRIVE; r.t = '{ONE, ONE, 32'd0}; r.lim = 31'h1_0000;
        r.rad = 31'h4_0000;
        add_row(r, 0, z);
        r.rad = 31'h0_8000;
        add_row(r, 0, z);
        // pursue and evade with a short look-ahead
        r = '0; r.t = '{32'h0010_0000, 32'd0, 32'd0}; r.v = '{32'd0, 32'hfff0_0000, ONE};
        r.lim = 31'h0100_0000;
        r.mode = MODE_PURSUE; add_row(r, 0, z);
        r.mode = MODE_EVADE;  add_row(r, 0, z);

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset look-ahead limit
        for (int k = 0; k < dir_req.size(); k++)
            send_item(dir_req[k], dir_has[k], dir_exp[k]);

        // random phases, each with its own limit and idle and stall mix
        for (int ph = 0; ph < 4; ph++) begin
            write_look_ahead(ph == 3 ? 31'($urandom()) : limits[ph]);
            idle_pct = idle_mix[ph];
            stall_pct = stall_mix[ph];
            for (int k = 0; k < 232; k++) begin
                if (ph == 1 && k == 20) hold_req <= 1'b1;
                if (k % 60 == 59) begin
                    idle_pct = 0;
                    stall_pct = 0;
                end else if (k % 60 == 0) begin
                    idle_pct = idle_mix[ph];
                    stall_pct = stall_mix[ph];
                end
                send_item(rand_req(), 0, z);
            end
        end
        in_valid <= 1'b0;
        stall_pct = 0;

        wait (pending_forces.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items (%0d results), modes seek..evade %0d/%0d/%0d/%0d/%0d,",
                 items_sent, forces_seen, mode_count[0], mode_count[1], mode_count[2],
                 mode_count[3], mode_count[4]);
        $display("unknown modes %0d, five look-ahead limits, four idle and stall mixes",
                 mode_count[5] + mode_count[6] + mode_count[7]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("timeout with %0d items still expected", pending_forces.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
